// ===== design/imucf_pkg.sv =====
`default_nettype none
package imucf_pkg;

  // sample and filter widths
  localparam int SAMPLE_BITS = 16;
  localparam int FILT_BITS   = 2 * SAMPLE_BITS + 1;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_AXES    = 3;
  localparam int AXIS_BITS   = 2;

  // register widths
  localparam int MAP_BITS      = 6;
  localparam int SIGN_BITS     = 3;
  localparam int BIAS_BITS     = 16;
  localparam int SCALE_BITS    = 16;
  localparam int WEIGHT_BITS   = 16;
  localparam int PACK_BITS     = NUM_AXES * BIAS_BITS;
  localparam int CFG_DATA_BITS = 48;
  localparam int CFG_IDX_BITS  = 3;

  // datapath widths
  localparam int DIFF_BITS  = ((SAMPLE_BITS > BIAS_BITS) ? SAMPLE_BITS : BIAS_BITS) + 1;
  localparam int MUL_A_BITS = FILT_BITS + 1;
  localparam int MUL_B_BITS = ((SCALE_BITS > WEIGHT_BITS) ? SCALE_BITS : WEIGHT_BITS) + 1;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [FILT_BITS-1:0]   filt_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // tracking start points, saturated to the sample range
  localparam int TRACK_MAG  = 10000;
  localparam int SMAX_INT   = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam sample_t TRACK_HI_INIT =
    sample_t'((TRACK_MAG > SMAX_INT) ? SMAX_INT : TRACK_MAG);
  localparam sample_t TRACK_LO_INIT =
    sample_t'((TRACK_MAG > SMAX_INT) ? (-SMAX_INT - 1) : -TRACK_MAG);

  // register reset values
  localparam logic [MAP_BITS-1:0]    AXIS_MAP_RST = MAP_BITS'(36);
  localparam logic [SIGN_BITS-1:0]   SIGN_RST     = '0;
  localparam logic [PACK_BITS-1:0]   BIAS_RST     = '0;
  localparam logic [PACK_BITS-1:0]   SCALE_RST    = '1;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RST   = '1;
  localparam logic                   TRACK_RST    = 1'b0;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_AXIS_MAP     = 3'd0,
    CFG_SIGN_MASK    = 3'd1,
    CFG_BIAS         = 3'd2,
    CFG_SCALE        = 3'd3,
    CFG_WEIGHT       = 3'd4,
    CFG_TRACK_ENABLE = 3'd5
  } cfg_idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic                 load;
    logic                 scale_step;
    logic                 weight_step;
    logic                 acc_step;
    logic                 out_load;
    logic [AXIS_BITS-1:0] axis;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ===== design/imucf_ctrl.sv =====
`default_nettype none
module imucf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output imucf_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_WEIGHT,
    S_LAST,
    S_FIN
  } state_t;

  localparam logic [imucf_pkg::AXIS_BITS-1:0] LAST_AXIS =
    imucf_pkg::AXIS_BITS'(imucf_pkg::NUM_AXES - 1);

  state_t                            state_r;
  logic [imucf_pkg::AXIS_BITS-1:0]   ax_r;
  logic                              out_valid_r;
  logic                              out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load        = (state_r == S_IDLE) && in_valid;
    cmd.scale_step  = (state_r == S_SCALE);
    cmd.weight_step = (state_r == S_WEIGHT);
    // accumulate the previous axis while the next one is scaled, and the last axis in S_LAST
    cmd.acc_step    = ((state_r == S_SCALE) && (ax_r != '0)) || (state_r == S_LAST);
    cmd.out_load    = (state_r == S_FIN) && out_free;
    cmd.axis        = ax_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_SCALE;
            ax_r    <= '0;
          end
        end
        S_SCALE: begin
          state_r <= S_WEIGHT;
        end
        S_WEIGHT: begin
          if (ax_r == LAST_AXIS) begin
            state_r <= S_LAST;
          end else begin
            ax_r    <= ax_r + 1'b1;
            state_r <= S_SCALE;
          end
        end
        S_LAST: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/imucf_dp.sv =====
`default_nettype none
module imucf_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [imucf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [imucf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire imucf_pkg::sample_t                     in_raw_x,
  input  wire imucf_pkg::sample_t                     in_raw_y,
  input  wire imucf_pkg::sample_t                     in_raw_z,
  input  wire imucf_pkg::dp_cmd_t                     cmd,
  output imucf_pkg::filt_t                            out_filtered_x,
  output imucf_pkg::filt_t                            out_filtered_y,
  output imucf_pkg::filt_t                            out_filtered_z,
  output imucf_pkg::sample_t                          out_min_x,
  output imucf_pkg::sample_t                          out_min_y,
  output imucf_pkg::sample_t                          out_min_z,
  output imucf_pkg::sample_t                          out_max_x,
  output imucf_pkg::sample_t                          out_max_y,
  output imucf_pkg::sample_t                          out_max_z
);

  localparam int NA = imucf_pkg::NUM_AXES;

  // configuration
  logic [imucf_pkg::MAP_BITS-1:0]    axis_map_r;
  logic [imucf_pkg::SIGN_BITS-1:0]   sign_mask_r;
  logic [imucf_pkg::PACK_BITS-1:0]   bias_r;
  logic [imucf_pkg::PACK_BITS-1:0]   scale_r;
  logic [imucf_pkg::WEIGHT_BITS-1:0] weight_r;
  logic                              track_en_r;

  // working state; in the filter and tracking arrays index 0 is the axis in work, rotated per step
  imucf_pkg::sample_t raw_r  [NA];
  imucf_pkg::filt_t   filt_r [NA];
  imucf_pkg::sample_t tmax_r [NA];
  imucf_pkg::sample_t tmin_r [NA];
  logic signed [imucf_pkg::PROD_BITS-1:0] prod_r;

  imucf_pkg::filt_t   ofilt_r [NA];
  imucf_pkg::sample_t omin_r  [NA];
  imucf_pkg::sample_t omax_r  [NA];

  logic [imucf_pkg::AXIS_BITS-1:0]          sel_raw;
  logic [imucf_pkg::AXIS_BITS-1:0]          sel;
  imucf_pkg::sample_t                       o_src;
  imucf_pkg::sample_t                       oriented;
  logic signed [imucf_pkg::BIAS_BITS-1:0]   bias;
  logic [imucf_pkg::SCALE_BITS-1:0]         scale;
  logic signed [imucf_pkg::DIFF_BITS-1:0]   dval;
  imucf_pkg::filt_t                         xval;
  logic signed [imucf_pkg::MUL_A_BITS-1:0]  fdiff;
  logic signed [imucf_pkg::MUL_A_BITS-1:0]  mul_a;
  logic signed [imucf_pkg::MUL_B_BITS-1:0]  mul_b;
  logic signed [imucf_pkg::PROD_BITS-1:0]   prod_nxt;
  imucf_pkg::filt_t                         filt_sum;
  imucf_pkg::sample_t                       tmax_nxt;
  imucf_pkg::sample_t                       tmin_nxt;

  // orientation: selector three reads z, negation saturates
  always_comb begin
    sel_raw = axis_map_r[{cmd.axis, 1'b0} +: imucf_pkg::AXIS_BITS];
    sel     = (sel_raw > imucf_pkg::AXIS_BITS'(NA - 1)) ?
              imucf_pkg::AXIS_BITS'(NA - 1) : sel_raw;
    o_src   = raw_r[sel];
    if (sign_mask_r[cmd.axis]) begin
      oriented = (o_src == imucf_pkg::SAMPLE_MIN) ? imucf_pkg::SAMPLE_MAX : -o_src;
    end else begin
      oriented = o_src;
    end
  end

  always_comb begin
    bias  = bias_r[imucf_pkg::BIAS_BITS * cmd.axis +: imucf_pkg::BIAS_BITS];
    scale = scale_r[imucf_pkg::SCALE_BITS * cmd.axis +: imucf_pkg::SCALE_BITS];
    dval  = imucf_pkg::DIFF_BITS'(oriented) - imucf_pkg::DIFF_BITS'(bias);
    xval  = imucf_pkg::filt_t'(prod_r[imucf_pkg::FILT_BITS-1:0]);
    fdiff = imucf_pkg::MUL_A_BITS'(xval) - imucf_pkg::MUL_A_BITS'(filt_r[0]);
    if (cmd.scale_step) begin
      mul_a = imucf_pkg::MUL_A_BITS'(dval);
      mul_b = $signed({1'b0, scale});
    end else begin
      mul_a = fdiff;
      mul_b = $signed({1'b0, weight_r});
    end
    prod_nxt = mul_a * mul_b;
    // arithmetic shift gives the floor of the weighted step
    filt_sum = filt_r[0] + imucf_pkg::filt_t'(prod_r[imucf_pkg::FRAC_BITS +: imucf_pkg::FILT_BITS]);
    tmax_nxt = (track_en_r && (oriented > tmax_r[0])) ? oriented : tmax_r[0];
    tmin_nxt = (track_en_r && (oriented < tmin_r[0])) ? oriented : tmin_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_map_r  <= imucf_pkg::AXIS_MAP_RST;
      sign_mask_r <= imucf_pkg::SIGN_RST;
      bias_r      <= imucf_pkg::BIAS_RST;
      scale_r     <= imucf_pkg::SCALE_RST;
      weight_r    <= imucf_pkg::WEIGHT_RST;
      track_en_r  <= imucf_pkg::TRACK_RST;
      for (int i = 0; i < NA; i++) begin
        filt_r[i] <= '0;
        tmax_r[i] <= imucf_pkg::TRACK_LO_INIT;
        tmin_r[i] <= imucf_pkg::TRACK_HI_INIT;
      end
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          imucf_pkg::CFG_AXIS_MAP:     axis_map_r  <= cfg_data[imucf_pkg::MAP_BITS-1:0];
          imucf_pkg::CFG_SIGN_MASK:    sign_mask_r <= cfg_data[imucf_pkg::SIGN_BITS-1:0];
          imucf_pkg::CFG_BIAS:         bias_r      <= cfg_data[imucf_pkg::PACK_BITS-1:0];
          imucf_pkg::CFG_SCALE:        scale_r     <= cfg_data[imucf_pkg::PACK_BITS-1:0];
          imucf_pkg::CFG_WEIGHT:       weight_r    <= cfg_data[imucf_pkg::WEIGHT_BITS-1:0];
          imucf_pkg::CFG_TRACK_ENABLE: track_en_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (cmd.acc_step) begin
        for (int i = 0; i < NA - 1; i++) begin
          filt_r[i] <= filt_r[i+1];
        end
        filt_r[NA-1] <= filt_sum;
      end
      if (cmd.scale_step) begin
        for (int i = 0; i < NA - 1; i++) begin
          tmax_r[i] <= tmax_r[i+1];
          tmin_r[i] <= tmin_r[i+1];
        end
        tmax_r[NA-1] <= tmax_nxt;
        tmin_r[NA-1] <= tmin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_r[0] <= in_raw_x;
      raw_r[1] <= in_raw_y;
      raw_r[2] <= in_raw_z;
    end
    if (cmd.scale_step || cmd.weight_step) begin
      prod_r <= prod_nxt;
    end
    if (cmd.out_load) begin
      for (int i = 0; i < NA; i++) begin
        ofilt_r[i] <= filt_r[i];
        omin_r[i]  <= tmin_r[i];
        omax_r[i]  <= tmax_r[i];
      end
    end
  end

  assign out_filtered_x = ofilt_r[0];
  assign out_filtered_y = ofilt_r[1];
  assign out_filtered_z = ofilt_r[2];
  assign out_min_x      = omin_r[0];
  assign out_min_y      = omin_r[1];
  assign out_min_z      = omin_r[2];
  assign out_max_x      = omax_r[0];
  assign out_max_y      = omax_r[1];
  assign out_max_z      = omax_r[2];

endmodule
`default_nettype wire

// ===== design/imu_axis_calibrate_filter.sv =====
`default_nettype none
// Conditions one three-axis sensor. Each input transaction carries a raw x/y/z
// sample; each output axis takes a configured source axis (selector three reads
// z), optionally negated with -32768 saturating to 32767, subtracts a signed
// bias, multiplies by an unsigned Q0.16 scale and runs a first-order low-pass
// y += floor(w*(x-y)/65536). One output transaction per input carries the three
// filter states (16 fractional bits) and, when tracking is enabled, the running
// min and max of the oriented axes. A new input is taken only once the previous
// item has left the datapath: one 34x17 multiplier is shared and used twice per
// axis (scale, then filter weight), with each axis's accumulate but the last
// overlapped with the next axis's scale step. The result sits in an output
// register, so a new input can be taken while the previous result waits; a
// finished item only stalls if the output register is still full. Configuration
// writes take effect at once and must only happen while the block is idle.
module imu_axis_calibrate_filter (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration write port
  input  wire logic                                cfg_wr_en,
  input  wire logic [imucf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [imucf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  // raw sample channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire imucf_pkg::sample_t                  in_raw_x,
  input  wire imucf_pkg::sample_t                  in_raw_y,
  input  wire imucf_pkg::sample_t                  in_raw_z,
  // filtered result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output imucf_pkg::filt_t                         out_filtered_x,
  output imucf_pkg::filt_t                         out_filtered_y,
  output imucf_pkg::filt_t                         out_filtered_z,
  output imucf_pkg::sample_t                       out_min_x,
  output imucf_pkg::sample_t                       out_min_y,
  output imucf_pkg::sample_t                       out_min_z,
  output imucf_pkg::sample_t                       out_max_x,
  output imucf_pkg::sample_t                       out_max_y,
  output imucf_pkg::sample_t                       out_max_z
);

  // sequencing commands from the controller to the datapath
  imucf_pkg::dp_cmd_t cmd;

  // controller: walks the three axes, two multiplier passes each
  imucf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: config registers, shared multiplier, filter and tracking state
  imucf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_raw_x       (in_raw_x),
    .in_raw_y       (in_raw_y),
    .in_raw_z       (in_raw_z),
    .cmd            (cmd),
    .out_filtered_x (out_filtered_x),
    .out_filtered_y (out_filtered_y),
    .out_filtered_z (out_filtered_z),
    .out_min_x      (out_min_x),
    .out_min_y      (out_min_y),
    .out_min_z      (out_min_z),
    .out_max_x      (out_max_x),
    .out_max_y      (out_max_y),
    .out_max_z      (out_max_z)
  );

endmodule
`default_nettype wire

// ===== sim/tb_imu_axis_calibrate_filter.sv =====
`default_nettype none
module tb_imu_axis_calibrate_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import imucf_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 12;
  localparam int RANDOM_PHASES   = 14;
  localparam int ITEMS_PER_PHASE = 100;
  // margin after the last result before the registers are touched again
  localparam int DRAIN_CYCLES    = 12;
  localparam int SETTLE_LIMIT    = 4000;
  // generous bound on the whole run
  localparam int TIMEOUT_NS      = 2_000_000;

  // register indexes past the end of the register file, writes there are dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

  // one output transaction: filter state and running min/max per axis
  typedef struct {
    filt_t   filt [NUM_AXES];
    sample_t lo   [NUM_AXES];
    sample_t hi   [NUM_AXES];
  } axis_result_t;

  // keeps its own copy of the registers and the per-axis state and works out
  // the filtered vector each accepted sample should produce
  class conditioning_scoreboard;
    logic [MAP_BITS-1:0]    map;
    logic [SIGN_BITS-1:0]   negate;
    logic [PACK_BITS-1:0]   bias;
    logic [PACK_BITS-1:0]   scale;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   track;
    longint                 lp_state [NUM_AXES];
    sample_t                run_lo   [NUM_AXES];
    sample_t                run_hi   [NUM_AXES];
    axis_result_t           conditioned_q [$];
    int                     fail_count;
    int                     samples_seen;
    int                     results_checked;
    int                     tracked_samples;
    int                     frozen_samples;

    function new();
      map    = 6'd36;
      negate = '0;
      bias   = '0;
      scale  = '1;
      weight = '1;
      track  = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        lp_state[i] = 0;
        run_hi[i]   = -16'sd10000;
        run_lo[i]   = 16'sd10000;
      end
      fail_count      = 0;
      samples_seen    = 0;
      results_checked = 0;
      tracked_samples = 0;
      frozen_samples  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_AXIS_MAP:     map    = data[MAP_BITS-1:0];
        CFG_SIGN_MASK:    negate = data[SIGN_BITS-1:0];
        CFG_BIAS:         bias   = data[PACK_BITS-1:0];
        CFG_SCALE:        scale  = data[PACK_BITS-1:0];
        CFG_WEIGHT:       weight = data[WEIGHT_BITS-1:0];
        CFG_TRACK_ENABLE: track  = data[0];
        default: ;
      endcase
    endfunction

    function void condition_sample(sample_t rx, sample_t ry, sample_t rz);
      sample_t      raw [NUM_AXES];
      axis_result_t r;
      longint       o;
      longint       d;
      longint       prod;
      longint       diff;
      int           sel;
      raw[0] = rx;
      raw[1] = ry;
      raw[2] = rz;
      for (int i = 0; i < NUM_AXES; i++) begin
        sel = int'(map[2*i +: 2]);
        if (sel > 2) sel = 2;  // selector three reads z
        o = longint'(raw[sel]);
        if (negate[i]) o = (o == -64'sd32768) ? 64'sd32767 : -o;
        if (track) begin
          if (o > longint'(run_hi[i])) run_hi[i] = sample_t'(o);
          if (o < longint'(run_lo[i])) run_lo[i] = sample_t'(o);
        end
        d    = o - longint'($signed(bias[16*i +: 16]));
        prod = d * longint'(scale[16*i +: 16]);
        diff = prod - lp_state[i];
        // arithmetic shift of a signed product is the floor division
        lp_state[i] = lp_state[i] + ((diff * longint'(weight)) >>> 16);
        r.filt[i] = filt_t'(lp_state[i]);
        r.lo[i]   = run_lo[i];
        r.hi[i]   = run_hi[i];
      end
      samples_seen++;
      if (track) tracked_samples++;
      if (weight == '0) frozen_samples++;
      conditioned_q.push_back(r);
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        fail_count++;
      end
    endfunction

    function void check_conditioned(axis_result_t got);
      axis_result_t want;
      string        axis;
      string        axes;
      axes = "xyz";
      if (conditioned_q.size() == 0) begin
        $error("output transaction with no sample waiting for it");
        fail_count++;
        return;
      end
      want = conditioned_q.pop_front();
      results_checked++;
      for (int i = 0; i < NUM_AXES; i++) begin
        axis = axes.substr(i, i);
        compare_field({"filtered_", axis}, longint'(want.filt[i]), longint'(got.filt[i]));
        compare_field({"min_", axis}, longint'(want.lo[i]), longint'(got.lo[i]));
        compare_field({"max_", axis}, longint'(want.hi[i]), longint'(got.hi[i]));
      end
    endfunction

    function int outstanding();
      return conditioned_q.size();
    endfunction

    function void close_out();
      if (conditioned_q.size() != 0) begin
        $error("%0d expected output transactions never arrived", conditioned_q.size());
        fail_count++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  sample_t                  in_raw_x;
  sample_t                  in_raw_y;
  sample_t                  in_raw_z;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  filt_t                    out_filtered_x;
  filt_t                    out_filtered_y;
  filt_t                    out_filtered_z;
  sample_t                  out_min_x;
  sample_t                  out_min_y;
  sample_t                  out_min_z;
  sample_t                  out_max_x;
  sample_t                  out_max_y;
  sample_t                  out_max_z;

  conditioning_scoreboard sb = new();

  // random idling on both channels; cleared for the closing phase
  bit idle_on    = 1'b1;
  int stall_left = 0;
  int settings   = 0;

  imu_axis_calibrate_filter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_raw_x       (in_raw_x),
    .in_raw_y       (in_raw_y),
    .in_raw_z       (in_raw_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_filtered_x (out_filtered_x),
    .out_filtered_y (out_filtered_y),
    .out_filtered_z (out_filtered_z),
    .out_min_x      (out_min_x),
    .out_min_y      (out_min_y),
    .out_min_z      (out_min_z),
    .out_max_x      (out_max_x),
    .out_max_y      (out_max_y),
    .out_max_z      (out_max_z)
  );

  always #(CLK_HALF) clk = ~clk;

  // everything is observed at the rising edge, where the drivers hold still
  always @(posedge clk) begin : observe
    axis_result_t got;
    if (rst_n) begin
      if (cfg_wr_en) sb.write_reg(cfg_index, cfg_data);
      // check before noting: a result never belongs to the sample taken at the same edge
      if (out_valid && out_ready) begin
        got.filt[0] = out_filtered_x;
        got.filt[1] = out_filtered_y;
        got.filt[2] = out_filtered_z;
        got.lo[0]   = out_min_x;
        got.lo[1]   = out_min_y;
        got.lo[2]   = out_min_z;
        got.hi[0]   = out_max_x;
        got.hi[1]   = out_max_y;
        got.hi[2]   = out_max_z;
        sb.check_conditioned(got);
      end
      if (in_valid && in_ready) sb.condition_sample(in_raw_x, in_raw_y, in_raw_z);
    end
  end

  // result side back-pressure: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left = int'($urandom_range(0, 2));
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [PACK_BITS-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[PACK_BITS-1:0];
  endfunction

  function automatic logic [15:0] edge16();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // per-lane values for the packed bias and scale registers
  function automatic logic [PACK_BITS-1:0] pick_lanes(int kind);
    logic [PACK_BITS-1:0] v;
    logic [31:0]          r;
    v = rand48();
    for (int i = 0; i < NUM_AXES; i++) begin
      r = $urandom_range(0, 400);
      case (kind)
        0:       v[16*i +: 16] = edge16();
        1:       v[16*i +: 16] = 16'(r - 32'd200);
        2:       v[16*i +: 16] = 16'hFFFF;
        default: ;
      endcase
    end
    return v;
  endfunction

  // uniform samples, some corners, some near a per-phase level; all near it in a steady phase
  function automatic sample_t pick_sample(bit steady, sample_t level);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (steady || roll >= 8) return sample_t'(level + sample_t'($urandom_range(0, 64)) - 16'sd32);
    if (roll >= 6) return sample_t'(edge16());
    return sample_t'($urandom_range(0, 65535));
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one input transaction, optionally preceded by an idle burst
  task automatic send_sample(input sample_t x, input sample_t y, input sample_t z);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_raw_x <= x;
    in_raw_y <= y;
    in_raw_z <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  // let every outstanding result arrive so the registers may be touched again
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() > 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_settings();
    logic [PACK_BITS-1:0] w;
    cfg_write(CFG_AXIS_MAP, rand48());
    cfg_write(CFG_SIGN_MASK, rand48());
    cfg_write(CFG_BIAS, pick_lanes(int'($urandom_range(0, 3))));
    cfg_write(CFG_SCALE, pick_lanes(int'($urandom_range(0, 3))));
    w = rand48();
    case ($urandom_range(0, 7))
      0:       w[15:0] = 16'h0000;  // frozen filter
      1:       w[15:0] = 16'h0001;
      2:       w[15:0] = 16'hFFFF;
      default: ;
    endcase
    cfg_write(CFG_WEIGHT, w);
    cfg_write(CFG_TRACK_ENABLE, rand48());
    if ($urandom_range(0, 3) == 0) cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                                             rand48());
    settings++;
  endtask

  initial begin : stimulus
    bit      steady;
    sample_t level;
    rst_n     = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_raw_x  = '0;
    in_raw_y  = '0;
    in_raw_z  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: straight mapping, unit-ish scale, weight near one
    settings++;
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sd1, -16'sd1, 16'sd0);
    send_sample(16'sh7FFF, 16'sh8000, 16'sd12345);
    settle();

    // x from y, y from x, z through selector three; all axes negated so the most
    // negative sample saturates; bias and scale lanes at corner values
    cfg_write(CFG_AXIS_MAP, 48'h0000_0000_0031);
    cfg_write(CFG_SIGN_MASK, 48'h0000_0000_0007);
    cfg_write(CFG_BIAS, {16'h8000, 16'h7FFF, 16'h0001});
    cfg_write(CFG_SCALE, {16'h0000, 16'h8000, 16'hFFFF});
    cfg_write(CFG_WEIGHT, 48'h0000_0000_0001);
    cfg_write(CFG_TRACK_ENABLE, 48'h0000_0000_0001);
    settings++;
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sd5, 16'sh7FFF);
    send_sample(-16'sd1, 16'sd1, -16'sd32767);
    send_sample(16'sd12345, -16'sd23456, 16'sh8000);
    settle();

    // weight zero with junk above the field, writes to unused indexes,
    // every selector set to three
    cfg_write(CFG_WEIGHT, 48'hFFFF_FFFF_0000);
    cfg_write(CFG_SPARE_LO, rand48());
    cfg_write(CFG_SPARE_HI, 48'hFFFF_FFFF_FFFF);
    cfg_write(CFG_AXIS_MAP, 48'hFFFF_FFFF_FFFF);
    cfg_write(CFG_SIGN_MASK, 48'hFFFF_FFFF_FFF8);
    settings++;
    send_sample(16'sh7FFF, 16'sh8000, 16'sd100);
    send_sample(16'sh8000, 16'sh7FFF, -16'sd100);
    send_sample(16'sd4096, 16'sd0, 16'sh7FFF);
    send_sample(-16'sd4096, 16'sd0, 16'sh8000);
    settle();

    // tracking off again (only bit zero counts), reversed mapping, y negated
    cfg_write(CFG_WEIGHT, 48'h0000_0000_FFFF);
    cfg_write(CFG_TRACK_ENABLE, 48'hFFFF_FFFF_FFFE);
    cfg_write(CFG_AXIS_MAP, 48'h0000_0000_0006);
    cfg_write(CFG_SIGN_MASK, 48'h0000_0000_0002);
    cfg_write(CFG_BIAS, rand48());
    cfg_write(CFG_SCALE, 48'hFFFF_FFFF_FFFF);
    settings++;
    send_sample(16'sh8000, 16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sd0, 16'sh8000);
    send_sample(16'sd300, -16'sd300, 16'sd0);
    send_sample(16'sh5555, 16'shAAAA, 16'sh0F0F);
    settle();

    // random register settings, each followed by a batch of samples
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p == RANDOM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      random_settings();
      steady = ($urandom_range(0, 3) == 0);
      level  = sample_t'($urandom_range(0, 65535));
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_sample(pick_sample(steady, level), pick_sample(steady, level),
                    pick_sample(steady, level));
      settle();
    end

    sb.close_out();
    $display("ran %0d samples across %0d register settings, %0d output transactions checked",
             sb.samples_seen, settings, sb.results_checked);
    $display("%0d samples with min/max tracking on, %0d with the filter weight at zero",
             sb.tracked_samples, sb.frozen_samples);
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $error("simulation timed out with %0d output transactions outstanding",
           sb.outstanding());
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
design/imucf_pkg.sv
design/imucf_ctrl.sv
design/imucf_dp.sv
design/imu_axis_calibrate_filter.sv
sim/tb_imu_axis_calibrate_filter.sv
